// ----- hw/rtl/arpc_pkg.sv -----
// Package with shared types, constants and codes of the ARP cache and responder.
package arpc_pkg;
  localparam int CACHE_ENTRIES = 16;
  localparam int PROXY_ENTRIES = 8;
  localparam int CIW = $clog2(CACHE_ENTRIES);
  localparam int PIW = $clog2(PROXY_ENTRIES);

  localparam logic [2:0] FN_RX     = 3'd0;
  localparam logic [2:0] FN_RESOLVE = 3'd1;
  localparam logic [2:0] FN_TICK   = 3'd2;
  localparam logic [2:0] FN_PINS   = 3'd3;
  localparam logic [2:0] FN_PDEL   = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_MISS  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;
  localparam logic [15:0] RX_OP_REQUEST = 16'd1;

  localparam logic [1:0] CFG_OWN_MAC = 2'd0;
  localparam logic [1:0] CFG_OWN_IP  = 2'd1;
  localparam logic [1:0] CFG_CTO     = 2'd2;
  localparam logic [1:0] CFG_ITO     = 2'd3;

  localparam logic [31:0] CTO_RESET = 32'd1200000;
  localparam logic [31:0] ITO_RESET = 32'd180000;

  localparam int IN_W  = 3 + 16 + 48 + 32 + 32 + 32;
  localparam int IN_WB = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W = 2 + 2 + 48 + 32 + 48 + 32 + 48;
  localparam int OUT_WB = ((OUT_W + 7) / 8) * 8;

  // Search request broadcast to every cell.
  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] now;
    logic [31:0] cto;
    logic [31:0] ito;
  } srch_t;

  // Result flowing along the chain of cells.
  typedef struct packed {
    logic          match;
    logic [CIW-1:0] match_idx;
    logic          free;
    logic [CIW-1:0] free_idx;
    logic          expd;
    logic [CIW-1:0] expd_idx;
    logic [31:0]   old_age;
    logic [CIW-1:0] old_idx;
  } scan_t;

  // Write command to the cells.
  typedef struct packed {
    logic          we;
    logic [CIW-1:0] idx;
    logic          wr_mac;
    logic [31:0]   ip;
    logic [47:0]   mac;
    logic          complete;
    logic [31:0]   stamp;
    logic          clear;
  } cwr_t;
endpackage

// ----- hw/rtl/arpc_cell.sv -----
// One cache entry with its stage of the lookup and victim-selection chain.
module arpc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [arpc_pkg::CIW-1:0] my_idx,
  input  arpc_pkg::srch_t      srch,
  input  arpc_pkg::scan_t      scan_in,
  output arpc_pkg::scan_t      scan_out,
  input  arpc_pkg::cwr_t       wr,
  output logic [47:0]          mac,
  output logic                 complete,
  output logic [31:0]          age
);
  import arpc_pkg::*;

  logic        valid_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic        comp_r;
  logic [31:0] stamp_r;
  logic        expired;
  logic        hit;
  scan_t       scan_r, scan_nxt;

  assign age = srch.now - stamp_r;
  assign mac = mac_r;
  assign complete = comp_r;
  assign expired = comp_r ? (age >= srch.cto) : (age > srch.ito);
  assign hit = valid_r && (ip_r == srch.ip);
  assign scan_out = scan_r;

  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.match && hit) begin
      scan_nxt.match = 1'b1;
      scan_nxt.match_idx = my_idx;
    end
    if (!scan_in.free && !valid_r) begin
      scan_nxt.free = 1'b1;
      scan_nxt.free_idx = my_idx;
    end
    if (!scan_in.expd && valid_r && expired) begin
      scan_nxt.expd = 1'b1;
      scan_nxt.expd_idx = my_idx;
    end
    if (my_idx == '0 || age > scan_in.old_age) begin
      scan_nxt.old_age = age;
      scan_nxt.old_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.clear) begin
      valid_r <= 1'b0;
    end else if (wr.we && wr.idx == my_idx) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && !wr.clear && wr.idx == my_idx) begin
      ip_r <= wr.ip;
      comp_r <= wr.complete;
      stamp_r <= wr.stamp;
      if (wr.wr_mac) begin
        mac_r <= wr.mac;
      end
    end
  end
endmodule

// ----- hw/rtl/arpc_proxy.sv -----
// Proxy address set with lookup, insert, delete and clear.
module arpc_proxy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] look_ip,
  output logic        has,
  input  logic        ins,
  input  logic        del,
  input  logic        clr
);
  import arpc_pkg::*;

  logic [PROXY_ENTRIES-1:0] valid_r;
  logic [31:0]              ip_r [PROXY_ENTRIES];
  logic [PROXY_ENTRIES-1:0] eq;
  logic [PROXY_ENTRIES-1:0] first_free;

  always_comb begin
    for (int i = 0; i < PROXY_ENTRIES; i++) begin
      eq[i] = valid_r[i] && (ip_r[i] == look_ip);
    end
    has = |eq;
    first_free = ~valid_r & (valid_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (del) begin
      valid_r <= valid_r & ~eq;
    end else if (ins && !has) begin
      valid_r <= valid_r | first_free;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PROXY_ENTRIES; i++) begin
      if (ins && !has && first_free[i]) begin
        ip_r[i] <= look_ip;
      end
    end
  end
endmodule

// ----- hw/rtl/arp_cache_and_responder_unit.sv -----
// Top level of the ARP cache and proxy-ARP responder.
// Requests arrive on the in_ channel; in_tdata packs func, rx_opcode,
// rx_sender_mac, rx_sender_ip, rx_target_ip and query_ip from bit 0 up.
// Each request is taken into a register, and the search result walks a
// chain of sixteen entry cells, one cell per cycle. At the end of the scan
// the result is captured, and the action is applied in the ACT state after it.
// At most one result leaves on the out_ channel through an output register;
// out_tuser carries out_kind and out_tdata the frame fields and the resolved MAC.
// The next request is taken once the block is idle and the result register
// is empty, so a new request is not taken before the last one is through.
// A stalled receiver holds the result and blocks new requests.
// Configuration writes on the cfg_ channel are always taken.
// Reset clears all valid bits and the clock, and sets the configuration registers to defaults.
module arp_cache_and_responder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // func, rx_opcode, rx_sender_mac, rx_sender_ip, rx_target_ip, query_ip
  input  logic [arpc_pkg::IN_WB-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_kind
  output logic [1:0]                out_tuser,
  // frame_opcode, frame_sender_mac, frame_sender_ip, frame_target_mac,
  // frame_target_ip, resolved_mac
  output logic [arpc_pkg::OUT_WB-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [47:0]               cfg_data
);
  import arpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ACT  = 2'd2;
  localparam logic [CIW:0] SCAN_LAST = (CIW+1)'(CACHE_ENTRIES);

  logic [1:0]  st_r, st_nxt;
  logic [CIW:0] scnt_r;
  logic [2:0]  func_r;
  logic [15:0] op_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r, tip_r, qip_r;
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r, cto_r, ito_r, now_r;
  scan_t       res_r;
  logic        ov_r;
  logic [1:0]  okind_r;
  logic [OUT_WB-1:0] odata_r;

  srch_t srch;
  scan_t chain [CACHE_ENTRIES+1];
  cwr_t  wr;
  logic [47:0] cmac [CACHE_ENTRIES];
  logic        ccomp [CACHE_ENTRIES];
  logic [31:0] cage [CACHE_ENTRIES];
  logic        phas;
  logic [CIW-1:0] slot, midx;
  logic        fresh;

  assign in_tready = (st_r == ST_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tuser = okind_r;
  assign out_tdata = odata_r;

  assign srch.ip  = (func_r == FN_RX) ? sip_r : qip_r;
  assign srch.now = now_r;
  assign srch.cto = cto_r;
  assign srch.ito = ito_r;
  assign chain[0] = '0;

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(CIW'(g)), .srch(srch),
      .scan_in(chain[g]), .scan_out(chain[g+1]), .wr(wr),
      .mac(cmac[g]), .complete(ccomp[g]), .age(cage[g])
    );
  end

  arpc_proxy u_proxy (
    .clk(clk), .rst_n(rst_n), .look_ip((func_r == FN_RX) ? tip_r : qip_r),
    .has(phas),
    .ins(st_r == ST_ACT && func_r == FN_PINS),
    .del(st_r == ST_ACT && func_r == FN_PDEL),
    .clr(st_r == ST_ACT && func_r == FN_CLEAR)
  );

  always_comb begin
    midx = res_r.match_idx;
    if (res_r.match) slot = res_r.match_idx;
    else if (res_r.free) slot = res_r.free_idx;
    else if (res_r.expd) slot = res_r.expd_idx;
    else slot = res_r.old_idx;
    fresh = res_r.match && ccomp[midx] && (cage[midx] < cto_r);
  end

  always_comb begin
    wr = '0;
    wr.idx = slot;
    wr.stamp = now_r;
    if (st_r == ST_ACT) begin
      case (func_r)
        FN_RX: begin
          wr.we = 1'b1; wr.wr_mac = 1'b1; wr.ip = sip_r; wr.mac = smac_r;
          wr.complete = 1'b1;
        end
        FN_RESOLVE: begin
          wr.we = !fresh; wr.wr_mac = !res_r.match; wr.ip = qip_r;
          wr.mac = '0; wr.complete = 1'b0;
        end
        FN_CLEAR: wr.clear = 1'b1;
        default: wr.we = 1'b0;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid && in_tready) st_nxt = ST_SCAN;
      ST_SCAN: if (scnt_r == SCAN_LAST) st_nxt = ST_ACT;
      ST_ACT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      now_r <= '0;
      own_mac_r <= '0;
      own_ip_r <= '0;
      cto_r <= CTO_RESET;
      ito_r <= ITO_RESET;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OWN_MAC: own_mac_r <= cfg_data;
          CFG_OWN_IP:  own_ip_r <= cfg_data[31:0];
          CFG_CTO:     cto_r <= cfg_data[31:0];
          CFG_ITO:     ito_r <= cfg_data[31:0];
          default:     own_ip_r <= own_ip_r;
        endcase
      end
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (st_r == ST_ACT) begin
        if (func_r == FN_TICK) now_r <= now_r + 32'd1;
        if (func_r == FN_RESOLVE) ov_r <= 1'b1;
        if (func_r == FN_RX && op_r == RX_OP_REQUEST &&
            (tip_r == own_ip_r || phas)) ov_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tdata[2:0];
      op_r   <= in_tdata[18:3];
      smac_r <= in_tdata[66:19];
      sip_r  <= in_tdata[98:67];
      tip_r  <= in_tdata[130:99];
      qip_r  <= in_tdata[162:131];
      scnt_r <= '0;
    end else if (st_r == ST_SCAN) begin
      scnt_r <= scnt_r + 1'b1;
    end
    if (st_r == ST_SCAN && scnt_r == SCAN_LAST) res_r <= chain[CACHE_ENTRIES];
    if (st_r == ST_ACT) begin
      if (func_r == FN_RESOLVE) begin
        if (fresh) begin
          okind_r <= KIND_HIT;
          odata_r <= {{(OUT_WB-210){1'b0}}, cmac[midx], 162'd0};
        end else begin
          okind_r <= KIND_MISS;
          odata_r <= {{(OUT_WB-210){1'b0}}, 48'd0, qip_r, 48'd0, own_ip_r,
                      own_mac_r, OP_REQUEST};
        end
      end else begin
        okind_r <= KIND_REPLY;
        odata_r <= {{(OUT_WB-210){1'b0}}, 48'd0, sip_r, smac_r,
                    (tip_r == own_ip_r) ? own_ip_r : tip_r, own_mac_r, OP_REPLY};
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |=> (st_r == ST_SCAN || st_r == ST_ACT))
    else $error("bad sequence");
endmodule

// ----- dv/tb_arp_cache_and_responder_unit.sv -----
// Self-checking testbench for the ARP cache and proxy-ARP responder unit.
`timescale 1ns / 100ps

module tb_arp_cache_and_responder_unit;
  import arpc_pkg::*;

  typedef struct packed {
    logic [31:0] qip;
    logic [31:0] tip;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [15:0] opc;
    logic [2:0]  func;
  } arp_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic [47:0] rmac;
  } arp_frame_t;

  class arp_scoreboard;
    logic [47:0] mac_r;
    logic [31:0] ip_r, cto, ito, clock_ms;
    bit          c_valid[CACHE_ENTRIES];
    logic [31:0] c_ip[CACHE_ENTRIES];
    logic [47:0] c_mac[CACHE_ENTRIES];
    bit          c_cmp[CACHE_ENTRIES];
    logic [31:0] c_stamp[CACHE_ENTRIES];
    bit          p_valid[PROXY_ENTRIES];
    logic [31:0] p_ip[PROXY_ENTRIES];
    arp_frame_t  pending[$];
    int          errors;

    function new();
      mac_r = '0;
      ip_r = '0;
      cto = CTO_RESET;
      ito = ITO_RESET;
      clock_ms = '0;
      errors = 0;
      foreach (c_valid[i]) c_valid[i] = 0;
      foreach (p_valid[i]) p_valid[i] = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, logic [47:0] data);
      case (idx)
        CFG_OWN_MAC: mac_r = data;
        CFG_OWN_IP:  ip_r = data[31:0];
        CFG_CTO:     cto = data[31:0];
        CFG_ITO:     ito = data[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] age_of(int i);
      return clock_ms - c_stamp[i];
    endfunction

    function bit is_expired(int i);
      if (c_cmp[i]) return age_of(i) >= cto;
      return age_of(i) > ito;
    endfunction

    function int lookup(logic [31:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (c_valid[i] && c_ip[i] == ip) return i;
      return -1;
    endfunction

    function int pick_slot(logic [31:0] ip);
      int best;
      logic [31:0] best_age;
      best = lookup(ip);
      if (best >= 0) return best;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (!c_valid[i]) return i;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (is_expired(i)) return i;
      best = 0;
      best_age = age_of(0);
      for (int i = 1; i < CACHE_ENTRIES; i++)
        if (age_of(i) > best_age) begin
          best = i;
          best_age = age_of(i);
        end
      return best;
    endfunction

    function bit is_proxy(logic [31:0] ip);
      for (int i = 0; i < PROXY_ENTRIES; i++)
        if (p_valid[i] && p_ip[i] == ip) return 1;
      return 0;
    endfunction

    function void note_request(arp_req_t r);
      int i;
      arp_frame_t f;
      f = '0;
      case (r.func)
        FN_RX: begin
          i = pick_slot(r.sip);
          c_valid[i] = 1;
          c_ip[i] = r.sip;
          c_mac[i] = r.smac;
          c_cmp[i] = 1;
          c_stamp[i] = clock_ms;
          if (r.opc == RX_OP_REQUEST && (r.tip == ip_r || is_proxy(r.tip))) begin
            f.kind = KIND_REPLY;
            f.op = OP_REPLY;
            f.smac = mac_r;
            f.sip = (r.tip == ip_r) ? ip_r : r.tip;
            f.tmac = r.smac;
            f.tip = r.sip;
            pending.push_back(f);
          end
        end
        FN_RESOLVE: begin
          i = lookup(r.qip);
          if (i >= 0 && c_cmp[i] && age_of(i) < cto) begin
            f.kind = KIND_HIT;
            f.rmac = c_mac[i];
          end else begin
            if (i < 0) begin
              i = pick_slot(r.qip);
              c_mac[i] = '0;
            end
            c_valid[i] = 1;
            c_ip[i] = r.qip;
            c_cmp[i] = 0;
            c_stamp[i] = clock_ms;
            f.kind = KIND_MISS;
            f.op = OP_REQUEST;
            f.smac = mac_r;
            f.sip = ip_r;
            f.tip = r.qip;
          end
          pending.push_back(f);
        end
        FN_TICK: clock_ms = clock_ms + 1;
        FN_PINS: begin
          if (!is_proxy(r.qip))
            for (i = 0; i < PROXY_ENTRIES; i++)
              if (!p_valid[i]) begin
                p_valid[i] = 1;
                p_ip[i] = r.qip;
                break;
              end
        end
        FN_PDEL: begin
          for (i = 0; i < PROXY_ENTRIES; i++)
            if (p_valid[i] && p_ip[i] == r.qip) p_valid[i] = 0;
        end
        FN_CLEAR: begin
          foreach (c_valid[k]) c_valid[k] = 0;
          foreach (p_valid[k]) p_valid[k] = 0;
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [1:0] kind, logic [OUT_WB-1:0] data);
      arp_frame_t e;
      if (pending.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind)
        report($sformatf("out_kind %0h, expected %0h", kind, e.kind));
      if (data[1:0] !== e.op)
        report($sformatf("frame_opcode %0h, expected %0h", data[1:0], e.op));
      if (data[49:2] !== e.smac)
        report($sformatf("frame_sender_mac %h, expected %h", data[49:2], e.smac));
      if (data[81:50] !== e.sip)
        report($sformatf("frame_sender_ip %h, expected %h", data[81:50], e.sip));
      if (data[129:82] !== e.tmac)
        report($sformatf("frame_target_mac %h, expected %h", data[129:82], e.tmac));
      if (data[161:130] !== e.tip)
        report($sformatf("frame_target_ip %h, expected %h", data[161:130], e.tip));
      if (data[209:162] !== e.rmac)
        report($sformatf("resolved_mac %h, expected %h", data[209:162], e.rmac));
    endtask
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_tvalid = 0;
  logic                in_tready;
  logic [IN_WB-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 0;
  logic [1:0]          out_tuser;
  logic [OUT_WB-1:0]   out_tdata;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = CFG_OWN_MAC;
  logic [47:0]         cfg_data = '0;

  arp_scoreboard sb = new();
  logic [31:0]   ip_pool[24];
  bit            gaps_on = 0;
  int            quiet_cycles = 0;

  always #5 clk = ~clk;

  arp_cache_and_responder_unit i_dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_request(arp_req_t'(in_tdata[IN_W-1:0]));
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("tb_arp_cache_and_responder_unit failed");
        $finish;
      end
    end
  end

  // Receiver side: random stalls while gaps are on, mostly short, a few long.
  initial begin
    int n;
    forever begin
      out_tready <= 1;
      n = $urandom_range(0, 99);
      if (gaps_on && n < 25) begin
        @(posedge clk);
        out_tready <= 0;
        repeat (n < 3 ? $urandom_range(10, 30) : $urandom_range(1, 3)) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  task automatic send(arp_req_t r);
    int n;
    n = $urandom_range(0, 99);
    if (gaps_on && n < 30) begin
      in_tvalid <= 0;
      repeat (n < 3 ? $urandom_range(10, 30) : $urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= IN_WB'(r);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_all(logic [47:0] mac, logic [31:0] ip, logic [31:0] c, logic [31:0] i);
    drain();
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_OWN_IP, {16'h0, ip});
    write_reg(CFG_CTO, {16'h0, c});
    write_reg(CFG_ITO, {16'h0, i});
  endtask

  function automatic arp_req_t mk(logic [2:0] f, logic [15:0] op, logic [47:0] smac,
                                  logic [31:0] sip, logic [31:0] tip, logic [31:0] qip);
    arp_req_t r;
    r.func = f;
    r.opc = op;
    r.smac = smac;
    r.sip = sip;
    r.tip = tip;
    r.qip = qip;
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 9) < 8) ? ip_pool[$urandom_range(0, 23)] : $urandom();
  endfunction

  function automatic arp_req_t rand_req();
    arp_req_t r;
    int n;
    r = mk(FN_TICK, RX_OP_REQUEST, rand_mac(), pick_ip(), pick_ip(), pick_ip());
    n = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) r.opc = 16'($urandom());
    else if ($urandom_range(0, 4) == 0) r.opc = 16'd2;
    case ($urandom_range(0, 3))
      0: r.tip = sb.ip_r;
      1: r.tip = ip_pool[$urandom_range(0, 11)];
      default: ;
    endcase
    if ($urandom_range(0, 1)) r.qip = ip_pool[$urandom_range(0, 11)];
    if (n < 35) r.func = FN_RX;
    else if (n < 65) r.func = FN_RESOLVE;
    else if (n < 85) r.func = FN_TICK;
    else if (n < 92) r.func = FN_PINS;
    else if (n < 98) r.func = FN_PDEL;
    else r.func = FN_CLEAR;
    return r;
  endfunction

  initial begin
    logic [47:0] m;
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Defaults: own IP zero, so a request aimed at zero is answered.
    m = rand_mac();
    send(mk(FN_RX, RX_OP_REQUEST, m, ip_pool[0], 32'h0, 32'h0));
    send(mk(FN_RESOLVE, 16'h0, '0, '0, '0, ip_pool[0]));

    set_all(48'hFFFF_FFFF_FFFF, ip_pool[1], 32'd6, 32'd3);
    send(mk(FN_RX, RX_OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, ip_pool[1], '0));
    send(mk(FN_RX, 16'd2, 48'h0, 32'h0, ip_pool[1], '0));
    send(mk(FN_RX, 16'hFFFF, m, ip_pool[2], ip_pool[1], '0));
    send(mk(FN_PINS, '0, '0, '0, '0, ip_pool[3]));
    send(mk(FN_PINS, '0, '0, '0, '0, ip_pool[3]));
    send(mk(FN_RX, RX_OP_REQUEST, m, ip_pool[4], ip_pool[3], '0));
    send(mk(FN_RESOLVE, '0, '0, '0, '0, ip_pool[4]));
    send(mk(FN_RESOLVE, '0, '0, '0, '0, ip_pool[5]));
    send(mk(FN_RESOLVE, '0, '0, '0, '0, ip_pool[5]));
    repeat (7) send(mk(FN_TICK, '0, '0, '0, '0, '0));
    send(mk(FN_RESOLVE, '0, '0, '0, '0, ip_pool[4]));
    send(mk(FN_PDEL, '0, '0, '0, '0, ip_pool[3]));
    send(mk(FN_PDEL, '0, '0, '0, '0, ip_pool[3]));
    send(mk(FN_RX, RX_OP_REQUEST, m, ip_pool[4], ip_pool[3], '0));
    send(mk(3'd6, RX_OP_REQUEST, m, ip_pool[6], ip_pool[1], ip_pool[6]));
    send(mk(3'd7, RX_OP_REQUEST, m, ip_pool[6], ip_pool[1], ip_pool[6]));
    send(mk(FN_CLEAR, '0, '0, '0, '0, '0));
    send(mk(FN_RESOLVE, '0, '0, '0, '0, ip_pool[0]));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(rand_mac(), ip_pool[2], 32'd1, 32'd1);
        1: set_all(48'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_all(rand_mac(), ip_pool[7], 32'd8, 32'd4);
        3: set_all(48'hFFFF_FFFF_FFFF, 32'h0, 32'd20, 32'd2);
        4: set_all(rand_mac(), $urandom(), 32'd3, 32'd10);
        default: set_all(rand_mac(), ip_pool[9], 32'd12, 32'd6);
      endcase
      gaps_on = ph[0];
      for (int k = 0; k < 250; k++) begin
        if (k == 120 && ph == 2) begin
          in_tvalid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 49) == 0)
          send(mk(3'($urandom_range(6, 7)), 16'($urandom()), rand_mac(), $urandom(),
                  $urandom(), $urandom()));
        send(rand_req());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_arp_cache_and_responder_unit passed");
    else
      $display("tb_arp_cache_and_responder_unit failed");
    $finish;
  end
endmodule
